// ===== rtl/gedc_pkg.sv =====
// Shared types and register codes for the banked GPIO edge detect controller.
`timescale 1ns / 1ps

package gedc_pkg;

  localparam int DATA_W  = 32;
  localparam int BANK_W  = 3;
  localparam int BIT_W   = 5;
  localparam int FIRST_W = BANK_W + BIT_W;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [3:0] REG_LEVEL   = 4'd0;
  localparam logic [3:0] REG_DIR     = 4'd1;
  localparam logic [3:0] REG_SETDIR  = 4'd2;
  localparam logic [3:0] REG_CLRDIR  = 4'd3;
  localparam logic [3:0] REG_RISE    = 4'd4;
  localparam logic [3:0] REG_FALL    = 4'd5;
  localparam logic [3:0] REG_SETRISE = 4'd6;
  localparam logic [3:0] REG_CLRRISE = 4'd7;
  localparam logic [3:0] REG_SETFALL = 4'd8;
  localparam logic [3:0] REG_CLRFALL = 4'd9;
  localparam logic [3:0] REG_STATUS  = 4'd10;
  localparam logic [3:0] REG_SETOUT  = 4'd11;
  localparam logic [3:0] REG_CLROUT  = 4'd12;
  localparam logic [3:0] REG_APMASK  = 4'd13;
  localparam logic [3:0] REG_EXTMASK = 4'd14;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BANK_W-1:0] bank_index;
    logic [3:0]        reg_select;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_sample;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [DATA_W-1:0]  drive_level;
    logic [DATA_W-1:0]  drive_enable;
    logic               irq_pending;
    logic [FIRST_W-1:0] first_pending;
  } out_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] drive_level;
    logic [DATA_W-1:0] drive_enable;
    logic              pend;
    logic [BIT_W-1:0]  first_bit;
  } lane_res_t;

endpackage

// ===== rtl/gedc_lane.sv =====
// One bank lane: bank registers, request decode, edge detect and per-bank priority encode.
`timescale 1ns / 1ps

module gedc_lane #(
  parameter int BANK_ID = 0,
  parameter int PINS    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  gedc_pkg::in_req_t   req,
  output gedc_pkg::lane_res_t res
);

  logic [PINS-1:0] level_r, dir_r, out_r, rise_r, fall_r, status_r, amask_r, emask_r;
  logic [PINS-1:0] level_nxt, dir_nxt, out_nxt, rise_nxt, fall_nxt, status_nxt;
  logic [PINS-1:0] amask_nxt, emask_nxt;
  logic [PINS-1:0] wd, smp, hits;
  logic            hit;

  assign hit = accept && (req.bank_index == gedc_pkg::BANK_W'(BANK_ID));
  assign wd  = req.write_data[PINS-1:0];
  assign smp = req.pin_sample[PINS-1:0];
  assign hits = ((smp & ~level_r & rise_r) | (~smp & level_r & fall_r)) & amask_r;

  always_comb begin
    level_nxt  = level_r;
    dir_nxt    = dir_r;
    out_nxt    = out_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    status_nxt = status_r;
    amask_nxt  = amask_r;
    emask_nxt  = emask_r;
    if (hit) begin
      if (req.req_type == gedc_pkg::REQ_WRITE) begin
        case (req.reg_select)
          gedc_pkg::REG_DIR:     dir_nxt    = wd;
          gedc_pkg::REG_SETDIR:  dir_nxt    = dir_r | wd;
          gedc_pkg::REG_CLRDIR:  dir_nxt    = dir_r & ~wd;
          gedc_pkg::REG_RISE:    rise_nxt   = wd;
          gedc_pkg::REG_FALL:    fall_nxt   = wd;
          gedc_pkg::REG_SETRISE: rise_nxt   = rise_r | wd;
          gedc_pkg::REG_CLRRISE: rise_nxt   = rise_r & ~wd;
          gedc_pkg::REG_SETFALL: fall_nxt   = fall_r | wd;
          gedc_pkg::REG_CLRFALL: fall_nxt   = fall_r & ~wd;
          gedc_pkg::REG_STATUS:  status_nxt = status_r & ~wd;
          gedc_pkg::REG_SETOUT:  out_nxt    = out_r | wd;
          gedc_pkg::REG_CLROUT:  out_nxt    = out_r & ~wd;
          gedc_pkg::REG_APMASK:  amask_nxt  = wd;
          gedc_pkg::REG_EXTMASK: emask_nxt  = wd;
          default: ;
        endcase
      end else if (req.req_type == gedc_pkg::REQ_TICK) begin
        status_nxt = status_r | hits;
        level_nxt  = smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      dir_r    <= '0;
      out_r    <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      status_r <= '0;
      amask_r  <= '0;
      emask_r  <= '0;
    end else begin
      level_r  <= level_nxt;
      dir_r    <= dir_nxt;
      out_r    <= out_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      status_r <= status_nxt;
      amask_r  <= amask_nxt;
      emask_r  <= emask_nxt;
    end
  end

  always_comb begin
    res = '0;
    case (req.reg_select)
      gedc_pkg::REG_LEVEL:   res.read_data[PINS-1:0] = level_nxt;
      gedc_pkg::REG_DIR:     res.read_data[PINS-1:0] = dir_nxt;
      gedc_pkg::REG_RISE:    res.read_data[PINS-1:0] = rise_nxt;
      gedc_pkg::REG_FALL:    res.read_data[PINS-1:0] = fall_nxt;
      gedc_pkg::REG_STATUS:  res.read_data[PINS-1:0] = status_nxt;
      gedc_pkg::REG_APMASK:  res.read_data[PINS-1:0] = amask_nxt;
      gedc_pkg::REG_EXTMASK: res.read_data[PINS-1:0] = emask_nxt;
      default: ;
    endcase
    res.drive_level[PINS-1:0]  = out_nxt;
    res.drive_enable[PINS-1:0] = dir_nxt;
    res.pend = |status_nxt;
    for (int i = PINS - 1; i >= 0; i--) begin
      if (status_nxt[i]) begin
        res.first_bit = gedc_pkg::BIT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/gedc_merge.sv =====
// Merge stage: pick the addressed bank's data and the lowest pending pin over all lanes.
`timescale 1ns / 1ps

module gedc_merge #(
  parameter int BANKS = 6
) (
  input  gedc_pkg::in_req_t   req,
  input  gedc_pkg::lane_res_t lane_res [BANKS],
  output gedc_pkg::out_res_t  res
);

  always_comb begin
    res = '0;
    for (int b = 0; b < BANKS; b++) begin
      if (req.bank_index == gedc_pkg::BANK_W'(b)) begin
        res.drive_level  = lane_res[b].drive_level;
        res.drive_enable = lane_res[b].drive_enable;
        if (req.req_type == gedc_pkg::REQ_READ) begin
          res.read_data = lane_res[b].read_data;
        end
      end
    end
    for (int b = BANKS - 1; b >= 0; b--) begin
      if (lane_res[b].pend) begin
        res.irq_pending   = 1'b1;
        res.first_pending = {gedc_pkg::BANK_W'(b), lane_res[b].first_bit};
      end
    end
  end

endmodule

// ===== rtl/gpio_edge_detect_controller_core.sv =====
// Top level of the banked GPIO controller with edge detection.
//
//   channel   dir   handshake             payload
//   request   in    in_valid / in_stall   in_req  (gedc_pkg::in_req_t)
//   result    out   out_valid / out_stall out_res (gedc_pkg::out_res_t)
//
// One request per cycle while in_stall is low; each result appears in the output
// register in the cycle after its request is taken. One lane per bank applies the
// request and encodes its lowest pending pin; the merge stage feeds the output register.
// Synchronous active-low reset clears all bank registers and the output valid.
// in_stall follows out_stall only while a result is held in the output register.
`timescale 1ns / 1ps

module gpio_edge_detect_controller_core #(
  parameter int BANK_COUNT    = 6,
  parameter int PINS_PER_BANK = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gedc_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output gedc_pkg::out_res_t out_res
);

  gedc_pkg::lane_res_t lane_res [BANK_COUNT];
  gedc_pkg::out_res_t  merged;
  gedc_pkg::out_res_t  res_r;
  logic                valid_r, valid_nxt;
  logic                accept;

  assign in_stall  = valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  for (genvar b = 0; b < BANK_COUNT; b++) begin : g_lane
    gedc_lane #(
      .BANK_ID (b),
      .PINS    (PINS_PER_BANK)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .accept (accept),
      .req    (in_req),
      .res    (lane_res[b])
    );
  end

  gedc_merge #(
    .BANKS (BANK_COUNT)
  ) u_merge (
    .req      (in_req),
    .lane_res (lane_res),
    .res      (merged)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= merged;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the banked GPIO edge detect controller core.
`timescale 1ns / 1ps

module tb;

  localparam int BANKS = 6;
  localparam int PINS = 32;
  localparam logic [31:0] PIN_MASK = (PINS == 32) ? 32'hFFFF_FFFF : ((32'd1 << PINS) - 32'd1);
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [3:0] REG_NONE = 4'd15;
  localparam int RANDOM_REQS = 550;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  gedc_pkg::in_req_t in_req;
  logic out_valid;
  logic out_stall = 1'b0;
  gedc_pkg::out_res_t out_res;

  logic [31:0] lvl [BANKS];
  logic [31:0] dir [BANKS];
  logic [31:0] out_latch [BANKS];
  logic [31:0] rise_en [BANKS];
  logic [31:0] fall_en [BANKS];
  logic [31:0] edge_st [BANKS];
  logic [31:0] det_mask [BANKS];
  logic [31:0] ext_mask [BANKS];

  gedc_pkg::out_res_t bank_view_q[$];
  gedc_pkg::in_req_t table_req[$];
  bit table_fixed[$];
  gedc_pkg::out_res_t table_res[$];

  bit req_fixed;
  gedc_pkg::out_res_t req_fixed_res;
  gedc_pkg::out_res_t want;
  int fails = 0;
  int cycles = 0;
  int burst_left;
  int stall_mode = 0;

  gpio_edge_detect_controller_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic gedc_pkg::out_res_t gpio_apply(gedc_pkg::in_req_t r);
    gedc_pkg::out_res_t res;
    logic [31:0] wd;
    logic [31:0] smp;
    logic [31:0] hits;
    int b;
    int i;
    int k;
    bit found;
    res = '0;
    wd = r.write_data & PIN_MASK;
    smp = r.pin_sample & PIN_MASK;
    if (r.bank_index < BANKS) begin
      b = r.bank_index;
      case (r.req_type)
        gedc_pkg::REQ_WRITE: begin
          case (r.reg_select)
            gedc_pkg::REG_DIR:     dir[b] = wd;
            gedc_pkg::REG_SETDIR:  dir[b] = dir[b] | wd;
            gedc_pkg::REG_CLRDIR:  dir[b] = dir[b] & ~wd;
            gedc_pkg::REG_RISE:    rise_en[b] = wd;
            gedc_pkg::REG_FALL:    fall_en[b] = wd;
            gedc_pkg::REG_SETRISE: rise_en[b] = rise_en[b] | wd;
            gedc_pkg::REG_CLRRISE: rise_en[b] = rise_en[b] & ~wd;
            gedc_pkg::REG_SETFALL: fall_en[b] = fall_en[b] | wd;
            gedc_pkg::REG_CLRFALL: fall_en[b] = fall_en[b] & ~wd;
            gedc_pkg::REG_STATUS:  edge_st[b] = edge_st[b] & ~wd;
            gedc_pkg::REG_SETOUT:  out_latch[b] = out_latch[b] | wd;
            gedc_pkg::REG_CLROUT:  out_latch[b] = out_latch[b] & ~wd;
            gedc_pkg::REG_APMASK:  det_mask[b] = wd;
            gedc_pkg::REG_EXTMASK: ext_mask[b] = wd;
            default: ;
          endcase
        end
        gedc_pkg::REQ_READ: begin
          case (r.reg_select)
            gedc_pkg::REG_LEVEL:   res.read_data = lvl[b];
            gedc_pkg::REG_DIR:     res.read_data = dir[b];
            gedc_pkg::REG_RISE:    res.read_data = rise_en[b];
            gedc_pkg::REG_FALL:    res.read_data = fall_en[b];
            gedc_pkg::REG_STATUS:  res.read_data = edge_st[b];
            gedc_pkg::REG_APMASK:  res.read_data = det_mask[b];
            gedc_pkg::REG_EXTMASK: res.read_data = ext_mask[b];
            default:               res.read_data = '0;
          endcase
        end
        gedc_pkg::REQ_TICK: begin
          hits = (((smp & ~lvl[b]) & rise_en[b]) | ((~smp & lvl[b]) & fall_en[b]))
                 & det_mask[b];
          edge_st[b] = (edge_st[b] | hits) & PIN_MASK;
          lvl[b] = smp;
        end
        default: ;
      endcase
      res.drive_level = out_latch[b];
      res.drive_enable = dir[b];
    end
    found = 1'b0;
    for (i = 0; i < BANKS && !found; i++) begin
      for (k = 0; k < 32 && !found; k++) begin
        if (edge_st[i][k]) begin
          found = 1'b1;
          res.first_pending = 8'(i * 32 + k);
        end
      end
    end
    res.irq_pending = found;
    return res;
  endfunction

  function automatic gedc_pkg::in_req_t req_of(logic [1:0] t, logic [2:0] b, logic [3:0] s,
                                               logic [31:0] wd, logic [31:0] smp);
    gedc_pkg::in_req_t r;
    r.req_type = t;
    r.bank_index = b;
    r.reg_select = s;
    r.write_data = wd;
    r.pin_sample = smp;
    return r;
  endfunction

  function automatic gedc_pkg::out_res_t res_of(logic [31:0] rd, logic [31:0] dl,
                                                logic [31:0] de, logic irq, logic [7:0] first);
    gedc_pkg::out_res_t e;
    e.read_data = rd;
    e.drive_level = dl;
    e.drive_enable = de;
    e.irq_pending = irq;
    e.first_pending = first;
    return e;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic gedc_pkg::in_req_t rand_req();
    gedc_pkg::in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.req_type = gedc_pkg::REQ_WRITE;
    else if (pick < 68) r.req_type = gedc_pkg::REQ_READ;
    else if (pick < 95) r.req_type = gedc_pkg::REQ_TICK;
    else r.req_type = REQ_NONE;
    r.bank_index = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(BANKS, 7))
                                                : 3'($urandom_range(0, BANKS - 1));
    r.reg_select = 4'($urandom_range(0, 15));
    if (r.req_type == gedc_pkg::REQ_WRITE && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 4))
        0: r.reg_select = gedc_pkg::REG_RISE;
        1: r.reg_select = gedc_pkg::REG_FALL;
        2: r.reg_select = gedc_pkg::REG_SETRISE;
        3: r.reg_select = gedc_pkg::REG_SETFALL;
        default: r.reg_select = gedc_pkg::REG_APMASK;
      endcase
    end
    r.write_data = rand_word();
    r.pin_sample = rand_word();
    return r;
  endfunction

  task automatic row(gedc_pkg::in_req_t r, bit fixed, gedc_pkg::out_res_t e);
    table_req.push_back(r);
    table_fixed.push_back(fixed);
    table_res.push_back(e);
  endtask

  task automatic send(gedc_pkg::in_req_t r, bit fixed, gedc_pkg::out_res_t e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req <= r;
    req_fixed <= fixed;
    req_fixed_res <= e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic chk(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bank_view_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
        fails++;
      end else begin
        want = bank_view_q.pop_front();
        chk("read_data", want.read_data, out_res.read_data);
        chk("drive_level", want.drive_level, out_res.drive_level);
        chk("drive_enable", want.drive_enable, out_res.drive_enable);
        chk("irq_pending", 32'(want.irq_pending), 32'(out_res.irq_pending));
        chk("first_pending", 32'(want.first_pending), 32'(out_res.first_pending));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want = gpio_apply(in_req);
      bank_view_q.push_back(req_fixed ? req_fixed_res : want);
    end
  end

  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (!rst_n) out_stall <= 1'b0;
    else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 4);
        2: out_stall <= (cycles % 8 < 5);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    req_fixed = 1'b0;
    req_fixed_res = '0;
    burst_left = 0;
    for (i = 0; i < BANKS; i++) begin
      lvl[i] = '0;
      dir[i] = '0;
      out_latch[i] = '0;
      rise_en[i] = '0;
      fall_en[i] = '0;
      edge_st[i] = '0;
      det_mask[i] = '0;
      ext_mask[i] = '0;
    end

    row(req_of(gedc_pkg::REQ_READ, 3'd0, gedc_pkg::REG_LEVEL, '0, '0), 1'b1,
        res_of('0, '0, '0, 1'b0, 8'd0));
    row(req_of(gedc_pkg::REQ_READ, 3'd5, gedc_pkg::REG_STATUS, '0, '0), 1'b1,
        res_of('0, '0, '0, 1'b0, 8'd0));
    row(req_of(gedc_pkg::REQ_WRITE, 3'd0, gedc_pkg::REG_DIR, '1, '0), 1'b1,
        res_of('0, '0, '1, 1'b0, 8'd0));
    row(req_of(gedc_pkg::REQ_WRITE, 3'd0, gedc_pkg::REG_SETOUT, '1, '0), 1'b1,
        res_of('0, '1, '1, 1'b0, 8'd0));
    row(req_of(gedc_pkg::REQ_READ, 3'd0, gedc_pkg::REG_SETOUT, '0, '0), 1'b1,
        res_of('0, '1, '1, 1'b0, 8'd0));
    row(req_of(gedc_pkg::REQ_WRITE, 3'd0, gedc_pkg::REG_CLROUT, 32'hFFFF_0000, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd0, gedc_pkg::REG_CLRDIR, 32'h0000_FFFF, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd1, gedc_pkg::REG_SETDIR, 32'h8000_0001, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_RISE, '1, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_FALL, 32'h0F0F_0F0F, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_CLRRISE, 32'h0000_0001, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_SETFALL, 32'h8000_0000, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_CLRFALL, 32'h0000_0010, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_APMASK, 32'hFFFF_FFFE, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_EXTMASK, 32'hDEAD_BEEF, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_TICK, 3'd2, gedc_pkg::REG_LEVEL, '0, '1), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_TICK, 3'd2, gedc_pkg::REG_LEVEL, '0, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_READ, 3'd2, gedc_pkg::REG_STATUS, '0, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_LEVEL, 32'h1234_5678, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_READ, 3'd2, gedc_pkg::REG_LEVEL, '0, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_STATUS, 32'hFFFF_0000, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_TICK, 3'd6, gedc_pkg::REG_LEVEL, '1, '1), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_READ, 3'd7, gedc_pkg::REG_DIR, '0, '0), 1'b0, '0);
    row(req_of(REQ_NONE, 3'd1, gedc_pkg::REG_DIR, '1, '1), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd1, REG_NONE, '1, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_READ, 3'd1, REG_NONE, '0, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_READ, 3'd2, gedc_pkg::REG_EXTMASK, '0, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd2, gedc_pkg::REG_STATUS, '1, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd5, gedc_pkg::REG_APMASK, 32'h8000_0000, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_WRITE, 3'd5, gedc_pkg::REG_SETRISE, 32'h8000_0000, '0), 1'b0, '0);
    row(req_of(gedc_pkg::REQ_TICK, 3'd5, gedc_pkg::REG_LEVEL, '0, 32'h8000_0000), 1'b1,
        res_of('0, '0, '0, 1'b1, 8'd191));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < table_req.size(); i++) send(table_req[i], table_fixed[i], table_res[i]);
    repeat (RANDOM_REQS) send(rand_req(), 1'b0, '0);

    in_valid <= 1'b0;
    req_fixed <= 1'b0;
    while (bank_view_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
